FILE: rtl/core/ssw_pkg.sv
package ssw_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int POS_BITS    = 32;
    localparam int BYTE_W      = 8;
    localparam int PIDX_W      = 6;
    localparam int PLEN_W      = 7;
    localparam int MPOS_W      = 32;
    localparam int START_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CMP_W       = (POS_BITS > START_W) ? POS_BITS : START_W;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    typedef enum logic {
        KIND_PATTERN = 1'b0,
        KIND_TEXT    = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        MODE_ANY   = 2'd0,
        MODE_START = 2'd1,
        MODE_END   = 2'd2,
        MODE_WHOLE = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_IGNORE_CASE    = 2'd1,
        CFG_MATCH_MODE     = 2'd2,
        CFG_START_OFFSET   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        kind_t              kind;
        logic [PIDX_W-1:0]  pattern_index;
        logic [BYTE_W-1:0]  data_byte;
        logic               last_byte;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [MPOS_W-1:0]  match_position;
    } out_item_t;

    // Per-cell controls, driven by the top level.
    typedef struct packed {
        logic shift;
        logic pat_we;
        logic tail;
        logic active;
        logic ignore_case;
    } cell_ctl_t;

    // What the window stage hands to the resolve stage for one text item.
    typedef struct packed {
        logic                a_ok;
        logic                b_ok;
        logic                last;
        logic [POS_BITS-1:0] s_a;
        logic [POS_BITS-1:0] s_b;
    } stage_t;

    function automatic logic is_word(input logic [BYTE_W-1:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
               ((c >= "0") && (c <= "9")) || (c == "_");
    endfunction

    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
        return ((c >= "A") && (c <= "Z")) ? (c + BYTE_W'(32)) : c;
    endfunction

    function automatic logic bytes_equal(input logic [BYTE_W-1:0] a,
                                         input logic [BYTE_W-1:0] b,
                                         input logic              ic);
        return (a == b) || (ic && (to_lower(a) == to_lower(b)));
    endfunction

    function automatic logic mode_ok(input mode_t mode, input logic bs, input logic be);
        logic r;
        unique case (mode)
            MODE_ANY:   r = 1'b1;
            MODE_START: r = bs;
            MODE_END:   r = be;
            MODE_WHOLE: r = bs && be;
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/ssw_cell.sv
module ssw_cell (
    input  logic                        aclk,
    input  ssw_pkg::cell_ctl_t          ctl,
    input  logic [ssw_pkg::BYTE_W-1:0]  cur_byte,
    input  logic [ssw_pkg::BYTE_W-1:0]  right_byte,
    output logic [ssw_pkg::BYTE_W-1:0]  win_byte,
    output logic                        eq_a,
    output logic                        eq_b
);
    import ssw_pkg::*;

    logic [BYTE_W-1:0] pat_reg;
    logic [BYTE_W-1:0] win_reg;
    logic [BYTE_W-1:0] win_next;
    logic              eqa_reg;
    logic              eqa_next;
    logic              eqb_reg;
    logic              eqb_next;

    // The tail cell takes the new text byte; the others take their right neighbor's.
    assign win_next = ctl.tail ? cur_byte : right_byte;

    // eq_a compares the window before the shift, eq_b the window after it.
    assign eqa_next = !ctl.active || bytes_equal(pat_reg, win_reg, ctl.ignore_case);
    assign eqb_next = !ctl.active || bytes_equal(pat_reg, win_next, ctl.ignore_case);

    always_ff @(posedge aclk) begin
        if (ctl.pat_we) begin
            pat_reg <= cur_byte;
        end
        if (ctl.shift) begin
            win_reg <= win_next;
            eqa_reg <= eqa_next;
            eqb_reg <= eqb_next;
        end
    end

    assign win_byte = win_reg;
    assign eq_a     = eqa_reg;
    assign eq_b     = eqb_reg;

endmodule

FILE: rtl/core/ssw_resolve.sv
module ssw_resolve (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                stage_valid,
    input  ssw_pkg::stage_t                     stage,
    input  logic [ssw_pkg::PATTERN_MAX-1:0]     eq_a,
    input  logic [ssw_pkg::PATTERN_MAX-1:0]     eq_b,
    input  logic [ssw_pkg::START_W-1:0]         start_offset,
    output logic                                advance,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ssw_pkg::out_item_t                  m_item
);
    import ssw_pkg::*;

    logic                seen_reg;
    logic                seen_next;
    logic [POS_BITS-1:0] first_reg;
    logic [POS_BITS-1:0] first_next;
    logic                hit_a;
    logic                hit_b;
    logic                m_valid_reg;
    out_item_t           m_item_reg;

    // A last item needs the output register; other items always move on.
    assign advance = stage_valid && (!stage.last || !m_valid_reg || m_ready);

    always_comb begin
        hit_a = !seen_reg && stage.a_ok && (&eq_a) &&
                (CMP_W'(stage.s_a) >= CMP_W'(start_offset));
        hit_b = !seen_reg && !hit_a && stage.b_ok && (&eq_b) &&
                (CMP_W'(stage.s_b) >= CMP_W'(start_offset));
        seen_next  = seen_reg || hit_a || hit_b;
        first_next = hit_a ? stage.s_a : (hit_b ? stage.s_b : first_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= 1'b0;
            first_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance && stage.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (advance) begin
                if (stage.last) begin
                    seen_reg                  <= 1'b0;
                    first_reg                 <= '0;
                    m_item_reg.found          <= seen_next;
                    m_item_reg.match_position <= seen_next ? MPOS_W'(first_next) : '0;
                end else begin
                    seen_reg  <= seen_next;
                    first_reg <= first_next;
                end
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

FILE: rtl/core/substring_search_word_modes_top.sv
// Streaming substring search. Pattern bytes are loaded by index through the
// input channel (kind 0), then text bytes stream in (kind 1), one item per
// clock unless a last item is held; the pattern is held in a row of 64
// identical cells, each keeping one pattern byte and one text byte of the
// sliding window and comparing the two, and the window shifts one cell per
// text item. The registered cell results are combined in the resolve stage,
// so a search's single result (found flag and start of the leftmost
// qualifying match) leaves the output register once the last_byte item has
// passed the stage register. The input keeps flowing while a result waits to
// be taken, until the last text item of the next search has to wait behind
// it. The position counter saturates at its maximum and bytes beyond it are
// not searched. Configuration is written through its own channel only while
// the block is idle, as the user must ensure; the block does not enforce it.
// A pattern byte may be reloaded at any time and affects later comparisons.
module substring_search_word_modes_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ssw_pkg::in_item_t                s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ssw_pkg::out_item_t               m_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ssw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssw_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ssw_pkg::*;

    logic [PLEN_W-1:0]   len_reg;
    logic                ignore_case_reg;
    mode_t               mode_reg;
    logic [START_W-1:0]  start_reg;

    logic [POS_BITS-1:0] pos_reg;
    logic [BYTE_W-1:0]   prev_reg;
    logic [BYTE_W-1:0]   lastb_reg;
    logic                v1_reg;
    stage_t              s1_reg;
    stage_t              s1_next;

    logic [PLEN_W-1:0]   len_c;
    logic [POS_BITS-1:0] len_p;
    logic [POS_BITS:0]   diff_a;
    logic [POS_BITS:0]   diff_b;
    logic                text_acc;
    logic                pat_acc;
    logic                search_on;
    logic                bs_a;
    logic                be_a;
    logic                bs_b;
    logic [BYTE_W-1:0]   win0_next;
    logic                advance;

    logic [BYTE_W-1:0]      win [PATTERN_MAX];
    logic [BYTE_W-1:0]      rb  [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] eq_a;
    logic [PATTERN_MAX-1:0] eq_b;
    cell_ctl_t              ctl [PATTERN_MAX];

    assign cfg_ready = 1'b1;
    assign s_ready   = !v1_reg || advance;
    assign text_acc  = s_valid && s_ready && (s_item.kind == KIND_TEXT);
    assign pat_acc   = s_valid && s_ready && (s_item.kind == KIND_PATTERN);

    assign len_c = (int'(len_reg) > PATTERN_MAX) ? PLEN_W'(PATTERN_MAX) : len_reg;
    assign len_p = POS_BITS'(len_c);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg         <= PLEN_W'(1);
            ignore_case_reg <= 1'b0;
            mode_reg        <= MODE_ANY;
            start_reg       <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PATTERN_LENGTH: len_reg         <= cfg_data[PLEN_W-1:0];
                CFG_IGNORE_CASE:    ignore_case_reg <= cfg_data[0];
                CFG_MATCH_MODE:     mode_reg        <= mode_t'(cfg_data[1:0]);
                CFG_START_OFFSET:   start_reg       <= cfg_data[START_W-1:0];
                default: ;
            endcase
        end
    end

    // Cell row. Cell i holds the text byte at position p - len + i.
    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        if (i == PATTERN_MAX - 1) begin : g_end
            assign rb[i] = '0;
        end else begin : g_mid
            assign rb[i] = win[i+1];
        end

        assign ctl[i].shift       = text_acc;
        assign ctl[i].pat_we      = pat_acc && (int'(s_item.pattern_index) == i);
        assign ctl[i].tail        = (int'(len_c) == i + 1);
        assign ctl[i].active      = (i < int'(len_c));
        assign ctl[i].ignore_case = ignore_case_reg;

        ssw_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl[i]),
            .cur_byte   (s_item.data_byte),
            .right_byte (rb[i]),
            .win_byte   (win[i]),
            .eq_a       (eq_a[i]),
            .eq_b       (eq_b[i])
        );
    end

    assign win0_next = (len_c == PLEN_W'(1)) ? s_item.data_byte : rb[0];

    // Candidate A ended on the previous byte; candidate B ends on this one
    // and only counts at the end of the text.
    always_comb begin
        diff_a    = {1'b0, pos_reg} - {1'b0, len_p};
        diff_b    = {1'b0, pos_reg} + (POS_BITS+1)'(1) - {1'b0, len_p};
        search_on = (pos_reg != POS_MAX) && (len_c != '0);
        bs_a      = (diff_a == '0) || (is_word(prev_reg) != is_word(win[0]));
        be_a      = is_word(s_item.data_byte) != is_word(lastb_reg);
        bs_b      = (diff_b == '0) || (is_word(win[0]) != is_word(win0_next));

        s1_next.a_ok = search_on && !diff_a[POS_BITS] && mode_ok(mode_reg, bs_a, be_a);
        s1_next.b_ok = search_on && s_item.last_byte && !diff_b[POS_BITS] &&
                       mode_ok(mode_reg, bs_b, 1'b1);
        s1_next.last = s_item.last_byte;
        s1_next.s_a  = diff_a[POS_BITS-1:0];
        s1_next.s_b  = diff_b[POS_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            v1_reg  <= 1'b0;
        end else begin
            if (text_acc) begin
                v1_reg <= 1'b1;
                if (s_item.last_byte) begin
                    pos_reg <= '0;
                end else if (pos_reg != POS_MAX) begin
                    pos_reg <= pos_reg + POS_BITS'(1);
                end
            end else if (advance) begin
                v1_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (text_acc) begin
            s1_reg    <= s1_next;
            prev_reg  <= win[0];
            lastb_reg <= s_item.data_byte;
        end
    end

    ssw_resolve u_resolve (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .stage_valid  (v1_reg),
        .stage        (s1_reg),
        .eq_a         (eq_a),
        .eq_b         (eq_b),
        .start_offset (start_reg),
        .advance      (advance),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item)
    );

endmodule

FILE: rtl/core/ssw_checker.sv
module ssw_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input ssw_pkg::in_item_t                s_item,
    input logic                             m_valid,
    input logic                             m_ready,
    input ssw_pkg::out_item_t               m_item
);
    import ssw_pkg::*;

    logic last_acc;

    assign last_acc = s_valid && s_ready && (s_item.kind == KIND_TEXT) && s_item.last_byte;

    // A search without a match reports position zero.
    a_no_match_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.found) |-> (m_item.match_position == '0))
        else $error("result without match carries a nonzero position");

    // The result of a search is on the output once its last text item has passed the stage register.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        last_acc |-> ##2 m_valid)
        else $error("no result after the last text item");

    // A new result only appears for a last text item that has passed through the stage register.
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(last_acc, 2))
        else $error("result without a last text item");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_item)))
        else $error("result dropped or changed while stalled");

endmodule

bind substring_search_word_modes_top ssw_checker u_ssw_checker (.*);

FILE: bench/testbench.sv
module testbench;
    import ssw_pkg::*;

    localparam int WIN_DEPTH = PATTERN_MAX + 1;
    localparam longint unsigned POS_TOP = (64'd1 << POS_BITS) - 64'd1;
    localparam int RANDOM_ITEMS = 1680;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD = 300;
    localparam int CYCLE_LIMIT = 600000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    substring_search_word_modes_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Register copies as the block should hold them.
    logic [PLEN_W-1:0] cfg_len;
    bit cfg_icase;
    mode_t cfg_mode;
    logic [START_W-1:0] cfg_start;

    // Search state of the block as predicted.
    logic [7:0] pat_mem[PATTERN_MAX];
    logic [7:0] text_win[WIN_DEPTH];
    longint unsigned text_pos;
    bit hit_seen;
    longint unsigned hit_start;

    out_item_t expected_matches[$];
    in_item_t pending_items[$];
    longint pushed_count = 0;
    longint accepted_count = 0;
    int n_errors = 0;

    // Stimulus side: the pattern as last queued, used to plant matches in text.
    logic [7:0] pat_copy[PATTERN_MAX];
    int gen_len = 1;
    bit gen_icase = 0;
    bit tx_burst = 0;
    bit rx_burst = 0;
    int hold_asks = 0;
    int hold_done = 0;
    int tx_gap = 0;
    int rx_wait = 0;
    int cycle_count = 0;

    function automatic bit word_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == "_";
    endfunction

    function automatic logic [7:0] fold_case(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // Byte at text position q, where p is the position of the byte now arriving.
    function automatic logic [7:0] window_byte(longint unsigned q, longint unsigned p,
                                               logic [7:0] cur);
        longint unsigned k;
        if (q == p)
            return cur;
        k = p - 1 - q;
        return (k < WIN_DEPTH) ? text_win[k] : 8'h00;
    endfunction

    function automatic bit qualifies(longint unsigned s, longint unsigned len,
                                     longint unsigned p, logic [7:0] cur, bit at_end);
        bit b_start;
        bit b_end;
        logic [7:0] a;
        logic [7:0] b;
        int i;
        if (s < 64'(cfg_start))
            return 0;
        for (i = 0; i < len; i++) begin
            a = pat_mem[i];
            b = window_byte(s + i, p, cur);
            if (a != b && !(cfg_icase && fold_case(a) == fold_case(b)))
                return 0;
        end
        if (cfg_mode == MODE_ANY)
            return 1;
        b_start = (s == 0) ||
            (word_char(window_byte(s - 1, p, cur)) != word_char(window_byte(s, p, cur)));
        b_end = at_end ||
            (word_char(window_byte(s + len, p, cur)) !=
             word_char(window_byte(s + len - 1, p, cur)));
        case (cfg_mode)
            MODE_START: return b_start;
            MODE_END:   return b_end;
            default:    return b_start && b_end;
        endcase
    endfunction

    function automatic void clear_search();
        int k;
        for (k = 0; k < WIN_DEPTH; k++)
            text_win[k] = 8'h00;
        text_pos = 0;
        hit_seen = 0;
        hit_start = 0;
    endfunction

    // Advances the predicted state by one accepted item.
    function automatic void track_item(in_item_t it);
        longint unsigned len;
        longint unsigned p;
        out_item_t r;
        int k;
        if (it.kind == KIND_PATTERN) begin
            pat_mem[it.pattern_index] = it.data_byte;
            return;
        end
        len = 64'(cfg_len);
        if (len > PATTERN_MAX)
            len = PATTERN_MAX;
        p = text_pos;
        if (p < POS_TOP && len > 0 && !hit_seen) begin
            // A candidate that ended on the previous byte; this byte follows it.
            if (p >= len && qualifies(p - len, len, p, it.data_byte, 0)) begin
                hit_seen = 1;
                hit_start = p - len;
            end
            if (!hit_seen && it.last_byte && p + 1 >= len &&
                qualifies(p + 1 - len, len, p, it.data_byte, 1)) begin
                hit_seen = 1;
                hit_start = p + 1 - len;
            end
        end
        for (k = WIN_DEPTH - 1; k > 0; k--)
            text_win[k] = text_win[k-1];
        text_win[0] = it.data_byte;
        if (text_pos < POS_TOP)
            text_pos++;
        if (it.last_byte) begin
            r.found = hit_seen;
            r.match_position = hit_seen ? hit_start[MPOS_W-1:0] : '0;
            expected_matches.push_back(r);
            clear_search();
        end
    endfunction

    // Sender: one item at a time from the pending queue, with a drawn gap after each.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                track_item(s_item);
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    s_item <= pending_items.pop_front();
                    s_valid <= 1'b1;
                    tx_gap = tx_burst ? 0 : $urandom_range(0, 14);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: a drawn wait after each result, or a long hold when asked.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_valid && m_ready)
                rx_wait = rx_burst ? 0 : $urandom_range(0, 14);
            if (hold_asks != hold_done) begin
                hold_done = hold_asks;
                rx_wait = LONG_HOLD;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_matches.size() == 0) begin
                n_errors++;
                $display("%0t: result with none expected: found %0b position %0d",
                         $realtime, m_item.found, m_item.match_position);
            end else begin
                want = expected_matches.pop_front();
                if (m_item.found !== want.found) begin
                    n_errors++;
                    $display("%0t: found mismatch: expected %0b actual %0b",
                             $realtime, want.found, m_item.found);
                end
                if (m_item.match_position !== want.match_position) begin
                    n_errors++;
                    $display("%0t: match_position mismatch: expected %0d actual %0d",
                             $realtime, want.match_position, m_item.match_position);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout at %0t with %0d results outstanding",
                     $realtime, expected_matches.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void queue_item(kind_t kind, logic [PIDX_W-1:0] idx,
                                       logic [7:0] data, bit last);
        in_item_t it;
        it.kind = kind;
        it.pattern_index = idx;
        it.data_byte = data;
        it.last_byte = last;
        if (kind == KIND_PATTERN)
            pat_copy[idx] = data;
        pending_items.push_back(it);
        pushed_count++;
    endfunction

    function automatic logic [7:0] filler();
        case ($urandom_range(0, 7))
            0:       return " ";
            1:       return "_";
            2:       return 8'($urandom_range(0, 255));
            3:       return "0" + 8'($urandom_range(0, 1));
            4:       return "A" + 8'($urandom_range(0, 1));
            default: return "a" + 8'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic logic [7:0] vary_case(logic [7:0] c);
        bit letter;
        letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        if (letter && $urandom_range(0, gen_icase ? 1 : 7) == 0)
            return c ^ 8'h20;
        return c;
    endfunction

    function automatic void load_pattern(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            queue_item(KIND_PATTERN, PIDX_W'(i), s[i], 0);
    endfunction

    function automatic void queue_text(string s, bit ends);
        int i;
        for (i = 0; i < s.len(); i++)
            queue_item(KIND_TEXT, '0, s[i], ends && i == s.len() - 1);
    endfunction

    // One search of n text bytes, usually with a copy of the pattern planted in it.
    function automatic void queue_search(int n, bit noise);
        logic [7:0] txt[$];
        int pos;
        int k;
        for (k = 0; k < n; k++)
            txt.push_back(noise ? 8'($urandom_range(0, 255)) : filler());
        if (gen_len > 0 && gen_len <= n && $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 3))
                0:       pos = 0;
                1:       pos = n - gen_len;
                default: pos = $urandom_range(0, n - gen_len);
            endcase
            for (k = 0; k < gen_len; k++)
                txt[pos+k] = vary_case(pat_copy[k]);
            if ($urandom_range(0, 1)) begin
                if (pos > 0)
                    txt[pos-1] = " ";
                if (pos + gen_len < n)
                    txt[pos+gen_len] = " ";
            end
        end
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 29) == 0)
                queue_item(KIND_PATTERN, PIDX_W'($urandom_range(0, 63)), filler(),
                           1'($urandom_range(0, 1)));
            queue_item(KIND_TEXT, PIDX_W'($urandom), txt[k], k == n - 1);
        end
    endfunction

    // Returns once every queued item is taken and every result has arrived.
    task automatic wait_idle();
        do
            @(posedge aclk);
        while (accepted_count != pushed_count || expected_matches.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Called at a rising edge; returns at the edge where the write is taken.
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            CFG_PATTERN_LENGTH: cfg_len = value[PLEN_W-1:0];
            CFG_IGNORE_CASE:    cfg_icase = value[0];
            CFG_MATCH_MODE:     cfg_mode = mode_t'(value[1:0]);
            default:            cfg_start = value[START_W-1:0];
        endcase
    endtask

    task automatic set_config(logic [PLEN_W-1:0] len, bit icase, mode_t mode,
                              logic [START_W-1:0] start);
        wait_idle();
        write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_IGNORE_CASE, CFG_DATA_W'(icase));
        write_reg(CFG_MATCH_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_START_OFFSET, CFG_DATA_W'(start));
        cfg_valid <= 1'b0;
        gen_len = (len > PATTERN_MAX) ? PATTERN_MAX : len;
        gen_icase = icase;
    endtask

    initial begin
        int i;
        int j;
        int r;
        longint base;
        logic [PLEN_W-1:0] len;
        logic [START_W-1:0] start;

        for (i = 0; i < PATTERN_MAX; i++) begin
            pat_mem[i] = 8'h00;
            pat_copy[i] = 8'h00;
        end
        cfg_len = 1;
        cfg_icase = 0;
        cfg_mode = MODE_ANY;
        cfg_start = 0;
        clear_search();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Fill every pattern entry first so that no comparison reads an unwritten one.
        for (i = 0; i < PATTERN_MAX; i++)
            queue_item(KIND_PATTERN, PIDX_W'(i), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));

        set_config(3, 0, MODE_ANY, 0);
        load_pattern("cat");
        queue_text("a cat", 1);
        set_config(3, 1, MODE_WHOLE, 0);
        load_pattern("CaT");
        queue_text("xcat cAt", 1);
        set_config(2, 0, MODE_START, 0);
        load_pattern("ab");
        queue_text("cab ab", 1);
        // The match ends at the last text byte, which counts as a boundary.
        set_config(2, 0, MODE_END, 0);
        queue_text("abc ab", 1);
        set_config(0, 0, MODE_ANY, 0);
        queue_text("q", 1);
        set_config(1, 0, MODE_ANY, '1);
        load_pattern("a");
        queue_text("aa", 1);
        set_config(1, 0, MODE_ANY, 2);
        queue_text("aaaa", 1);
        // Reloading the pattern in mid-search changes what later bytes compare against.
        set_config(1, 0, MODE_ANY, 0);
        queue_text("xb", 0);
        load_pattern("b");
        queue_text("b", 1);

        // Many short searches against a stalled receiver, to fill the block up.
        set_config(2, 0, MODE_ANY, 0);
        tx_burst = 1;
        rx_burst = 0;
        hold_asks++;
        for (i = 0; i < 80; i++)
            queue_search($urandom_range(1, 3), 0);

        base = pushed_count;
        while (pushed_count - base < RANDOM_ITEMS) begin
            r = $urandom_range(0, 15);
            if (r == 0)
                len = '0;
            else if (r == 1)
                len = PLEN_W'($urandom_range(65, 127));
            else if (r < 4)
                len = PLEN_W'($urandom_range(9, 64));
            else
                len = PLEN_W'($urandom_range(1, 8));
            r = $urandom_range(0, 15);
            if (r == 0)
                start = '1;
            else if (r == 1)
                start = $urandom;
            else if (r < 6)
                start = $urandom_range(0, 12);
            else
                start = '0;
            set_config(len, 1'($urandom_range(0, 1)), mode_t'($urandom_range(0, 3)), start);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1))
                for (j = 0; j < gen_len; j++)
                    queue_item(KIND_PATTERN, PIDX_W'(j),
                               ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                           : filler(),
                               1'($urandom_range(0, 1)));
            for (i = $urandom_range(1, 4); i > 0; i--) begin
                if (gen_len > 8 && $urandom_range(0, 1))
                    r = gen_len + $urandom_range(0, 8);
                else
                    r = $urandom_range(1, 20);
                queue_search(r, $urandom_range(0, 9) == 0);
            end
        end

        wait_idle();
        if (n_errors == 0 && expected_matches.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
